### rtl/demand_paging_frame_allocator_unit_macros.svh
// Assertion macros shared by the paging unit's RTL.
`ifndef DEMAND_PAGING_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define DEMAND_PAGING_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DPFA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DPFA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpfa_pkg.sv
// Types, constants and helpers of the demand paging frame allocator.
package dpfa_pkg;

  localparam int unsigned PAGE_BYTES = 32;
  localparam int unsigned PHYS_BYTES = 8192;
  localparam int unsigned VIRT_BYTES = 512;
  localparam int unsigned PROCESSES  = 8;

  localparam int unsigned NFRAMES    = PHYS_BYTES / PAGE_BYTES;
  localparam int unsigned VPAGES     = VIRT_BYTES / PAGE_BYTES;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned FRAME_W    = $clog2(NFRAMES);
  localparam int unsigned VP_W       = $clog2(VPAGES);
  localparam int unsigned SLOT_W     = $clog2(PROCESSES);
  localparam int unsigned PTE_DEPTH  = PROCESSES * VPAGES;
  localparam int unsigned PTE_AW     = $clog2(PTE_DEPTH);
  localparam int unsigned RSV_W      = $clog2(NFRAMES) + 1;

  // Frame occupancy map: words of OCC_W bits
  localparam int unsigned OCC_W      = 16;
  localparam int unsigned OCC_WORDS  = NFRAMES / OCC_W;
  localparam int unsigned OCC_AW     = $clog2(OCC_WORDS);
  localparam int unsigned OCC_BW     = $clog2(OCC_W);

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_ACCESS = 2'd1,
    OP_EXIT   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BOUNDS      = 3'd1,
    ST_NO_PAGES    = 3'd2,
    ST_NO_SLOT     = 3'd3,
    ST_NOT_RUNNING = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  pid;
    logic [8:0]  addr;
    logic [9:0]  length;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [3:0]  virtual_page;
    logic [7:0]  frame;
    logic        newly_mapped;
    logic        page_valid;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_LOOK,
    S_A_HIT,
    S_A_ALLOC,
    S_X_LOOK,
    S_X_PTE,
    S_X_FREE,
    S_X_DONE
  } state_e;

  // Pages covered by a byte count, rounded up
  function automatic logic [9:0] pages_for(input logic [9:0] bytes);
    logic [10:0] sum;
    sum = {1'b0, bytes} + 11'(PAGE_BYTES - 1);
    pages_for = 10'(sum >> PAGE_SHIFT);
  endfunction

endpackage

### rtl/demand_paging_frame_allocator_unit.sv
// Demand paging unit: process slots, page tables and first-fit frame allocator.
//
// Usage: requests enter on in_valid_i/in_ready_o as in_item_t (create, access,
// exit); result items leave on out_valid_o/out_ready_i as out_item_t, one per
// create, exit or rejected access and one per page for an access, the final one with last set.
// One request is worked on at a time; in_ready_o is high only between requests.
// Steps, from the accepting edge to the edge that loads the result register:
// create and any rejected request are decided on decode; opcode three gives no result.
// An access has a decode step, then per page a look-up on the present bits,
// then a page table read for a mapped page or an occupancy word read-modify-write
// for a page that gets a new frame.
// An exit has a decode step, then walks all 16 page entries (a look-up for each page,
// plus an occupancy word read and write for a present page), then a final step.
// The next request can be accepted in the cycle after the final result is loaded.
// These steps are set by the single port of each RAM.
// Reset clears slots, reservation count, present bits and the occupancy
// summary at once; RAM contents are masked by valid bits, so no clearing pass.
// A stalled receiver holds the result register; an access walk waits on it
// and no item is lost, while a new request may be accepted
// while the last result waits.
`include "demand_paging_frame_allocator_unit_macros.svh"

module demand_paging_frame_allocator_unit
  import dpfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e state_q, state_d;
  in_item_t req_q;
  logic [VP_W-1:0] v_q, v_d, final_q, final_d;
  logic [OCC_AW-1:0] word_q, word_d;
  logic [PROCESSES-1:0] running_q, running_d;
  logic [9:0] size_q [PROCESSES];
  logic [9:0] size_d [PROCESSES];
  logic [RSV_W-1:0] rsv_q, rsv_d;
  logic [PTE_DEPTH-1:0] present_q, present_d;
  logic [OCC_WORDS-1:0] occ_full_q, occ_full_d, occ_valid_q, occ_valid_d;
  logic out_valid_q;
  out_item_t out_q;

  // RAM ports
  logic pte_we, pte_re, occ_we, occ_re;
  logic [PTE_AW-1:0] pte_addr;
  logic [FRAME_W-1:0] pte_wdata, pte_rdata;
  logic [OCC_AW-1:0] occ_addr;
  logic [OCC_W-1:0] occ_wdata, occ_rdata;

  logic emit;
  out_item_t res;

  dpfa_ram #(.WIDTH(FRAME_W), .DEPTH(PTE_DEPTH)) u_pte_ram (
    .clk_i   (clk_i),
    .we_i    (pte_we),
    .re_i    (pte_re),
    .addr_i  (pte_addr),
    .wdata_i (pte_wdata),
    .rdata_o (pte_rdata)
  );

  dpfa_ram #(.WIDTH(OCC_W), .DEPTH(OCC_WORDS)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .re_i    (occ_re),
    .addr_i  (occ_addr),
    .wdata_i (occ_wdata),
    .rdata_o (occ_rdata)
  );

  // Shared decode
  logic out_free;
  logic [SLOT_W-1:0] pid;
  logic [PTE_AW-1:0] pte_idx;
  logic present_cur;
  logic [9:0] need_c, need_x;
  logic [10:0] rsv_sum, acc_end, acc_lastb;
  logic create_big, create_nopg;
  logic slot_found;
  logic [SLOT_W-1:0] slot_free;
  logic fw_found;
  logic [OCC_AW-1:0] fw_idx;
  logic [OCC_W-1:0] word_eff;
  logic [OCC_BW-1:0] bit_free;
  logic pid_ok, acc_oob, acc_zero, v_is_final, v_is_end;

  assign out_free   = !out_valid_q || out_ready_i;
  assign pid        = SLOT_W'(req_q.pid);
  assign pte_idx    = {pid, v_q};
  assign present_cur = present_q[pte_idx];
  assign need_c     = pages_for(req_q.length);
  assign need_x     = pages_for(size_q[pid]);
  assign rsv_sum    = 11'(rsv_q) + 11'(need_c);
  assign create_big = req_q.length > 10'(VIRT_BYTES);
  assign create_nopg = rsv_sum > 11'(NFRAMES);
  assign pid_ok     = ({1'b0, req_q.pid} < 4'(PROCESSES)) && running_q[pid];
  assign acc_end    = 11'(req_q.addr) + 11'(req_q.length);
  assign acc_lastb  = acc_end - 11'd1;
  assign acc_oob    = acc_end > 11'(size_q[pid]);
  assign acc_zero   = req_q.length == 10'd0;
  assign v_is_final = v_q == final_q;
  assign v_is_end   = v_q == VP_W'(VPAGES - 1);
  assign word_eff   = occ_valid_q[word_q] ? occ_rdata : '0;

  // Lowest free slot
  always_comb begin
    slot_found = 1'b0;
    slot_free  = '0;
    for (int i = PROCESSES - 1; i >= 0; i--) begin
      if (!running_q[i]) begin
        slot_found = 1'b1;
        slot_free  = SLOT_W'(i);
      end
    end
  end

  // Lowest occupancy word that still has a free frame
  always_comb begin
    fw_found = 1'b0;
    fw_idx   = '0;
    for (int i = OCC_WORDS - 1; i >= 0; i--) begin
      if (!occ_full_q[i]) begin
        fw_found = 1'b1;
        fw_idx   = OCC_AW'(i);
      end
    end
  end

  // Lowest free frame inside the fetched word
  always_comb begin
    bit_free = '0;
    for (int i = OCC_W - 1; i >= 0; i--) begin
      if (!word_eff[i]) begin
        bit_free = OCC_BW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (req_q.op == OP_NONE) begin
          state_d = S_IDLE;
        end else if (req_q.op == OP_CREATE || !pid_ok ||
                     (req_q.op == OP_ACCESS && (acc_oob || acc_zero))) begin
          if (out_free) state_d = S_IDLE;
        end else if (req_q.op == OP_ACCESS) begin
          state_d = S_A_LOOK;
        end else begin
          state_d = S_X_LOOK;
        end
      end
      S_A_LOOK: begin
        if (present_cur) begin
          state_d = S_A_HIT;
        end else if (fw_found) begin
          state_d = S_A_ALLOC;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_A_HIT, S_A_ALLOC: begin
        if (out_free) state_d = v_is_final ? S_IDLE : S_A_LOOK;
      end
      S_X_LOOK: begin
        if (present_cur) begin
          state_d = S_X_PTE;
        end else if (v_is_end) begin
          state_d = S_X_DONE;
        end
      end
      S_X_PTE: state_d = S_X_FREE;
      S_X_FREE: state_d = v_is_end ? S_X_DONE : S_X_LOOK;
      S_X_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM control and results
  always_comb begin
    emit        = 1'b0;
    res         = '0;
    res.slot    = req_q.pid;
    res.last    = 1'b1;
    pte_we      = 1'b0;
    pte_re      = 1'b0;
    pte_addr    = pte_idx;
    pte_wdata   = {word_q, bit_free};
    occ_we      = 1'b0;
    occ_re      = 1'b0;
    occ_addr    = word_q;
    occ_wdata   = word_eff;
    v_d         = v_q;
    final_d     = final_q;
    word_d      = word_q;
    running_d   = running_q;
    size_d      = size_q;
    rsv_d       = rsv_q;
    present_d   = present_q;
    occ_full_d  = occ_full_q;
    occ_valid_d = occ_valid_q;
    unique case (state_q)
      S_DISPATCH: begin
        if (req_q.op == OP_CREATE) begin
          emit     = out_free;
          res.slot = '0;
          if (create_big) begin
            res.status = ST_BOUNDS;
          end else if (create_nopg) begin
            res.status = ST_NO_PAGES;
          end else if (!slot_found) begin
            res.status = ST_NO_SLOT;
          end else begin
            res.status = ST_OK;
            res.slot   = slot_free;
            if (out_free) begin
              running_d[slot_free] = 1'b1;
              size_d[slot_free]    = req_q.length;
              rsv_d                = RSV_W'(rsv_sum);
              for (int i = 0; i < VPAGES; i++) begin
                present_d[{slot_free, VP_W'(i)}] = 1'b0;
              end
            end
          end
        end else if (req_q.op != OP_NONE) begin
          if (!pid_ok) begin
            emit       = out_free;
            res.status = ST_NOT_RUNNING;
          end else if (req_q.op == OP_ACCESS) begin
            if (acc_oob) begin
              emit       = out_free;
              res.status = ST_BOUNDS;
            end else if (acc_zero) begin
              emit       = out_free;
              res.status = ST_OK;
            end else begin
              v_d     = VP_W'(req_q.addr >> PAGE_SHIFT);
              final_d = VP_W'(acc_lastb >> PAGE_SHIFT);
            end
          end else begin
            v_d = '0;
          end
        end
      end
      S_A_LOOK: begin
        if (present_cur) begin
          pte_re = 1'b1;
        end else if (fw_found) begin
          occ_re   = 1'b1;
          occ_addr = fw_idx;
          word_d   = fw_idx;
        end else begin
          // no free frame at all: report and stop the walk
          emit             = out_free;
          res.status       = ST_NO_PAGES;
          res.virtual_page = v_q;
        end
      end
      S_A_HIT: begin
        emit             = out_free;
        res.status       = ST_OK;
        res.virtual_page = v_q;
        res.frame        = pte_rdata;
        res.page_valid   = 1'b1;
        res.last         = v_is_final;
        if (out_free && !v_is_final) v_d = v_q + 1'b1;
      end
      S_A_ALLOC: begin
        emit             = out_free;
        res.status       = ST_OK;
        res.virtual_page = v_q;
        res.frame        = {word_q, bit_free};
        res.newly_mapped = 1'b1;
        res.page_valid   = 1'b1;
        res.last         = v_is_final;
        occ_wdata[bit_free] = 1'b1;
        if (out_free) begin
          occ_we              = 1'b1;
          pte_we              = 1'b1;
          occ_valid_d[word_q] = 1'b1;
          occ_full_d[word_q]  = &occ_wdata;
          present_d[pte_idx]  = 1'b1;
          if (!v_is_final) v_d = v_q + 1'b1;
        end
      end
      S_X_LOOK: begin
        if (present_cur) begin
          pte_re = 1'b1;
        end else if (!v_is_end) begin
          v_d = v_q + 1'b1;
        end
      end
      S_X_PTE: begin
        occ_re   = 1'b1;
        occ_addr = pte_rdata[FRAME_W-1 -: OCC_AW];
        word_d   = pte_rdata[FRAME_W-1 -: OCC_AW];
      end
      S_X_FREE: begin
        occ_wdata[pte_rdata[OCC_BW-1:0]] = 1'b0;
        occ_we              = 1'b1;
        occ_valid_d[word_q] = 1'b1;
        occ_full_d[word_q]  = 1'b0;
        present_d[pte_idx]  = 1'b0;
        if (!v_is_end) v_d = v_q + 1'b1;
      end
      S_X_DONE: begin
        emit       = out_free;
        res.status = ST_OK;
        if (out_free) begin
          running_d[pid] = 1'b0;
          size_d[pid]    = '0;
          rsv_d = (10'(rsv_q) >= need_x) ? RSV_W'(10'(rsv_q) - need_x) : '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      size_q      <= '{default: '0};
      rsv_q       <= '0;
      present_q   <= '0;
      occ_full_q  <= '0;
      occ_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      size_q      <= size_d;
      rsv_q       <= rsv_d;
      present_q   <= present_d;
      occ_full_q  <= occ_full_d;
      occ_valid_q <= occ_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_item_i;
    if (emit) out_q <= res;
    v_q     <= v_d;
    final_q <= final_d;
    word_q  <= word_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `DPFA_ASSERT_IMPL(a_rsv_bound, 1'b1, rsv_q <= RSV_W'(NFRAMES), "reservation above frames")
  `DPFA_ASSERT_IMPL(a_alloc_word, state_q == S_A_ALLOC, !occ_full_q[word_q], "alloc from full word")
  `DPFA_ASSERT_NEXT(a_exit_done, state_q == S_X_FREE && v_is_end, state_q == S_X_DONE, "exit walk")
  `DPFA_ASSERT_IMPL(a_map_ok, out_valid_q && out_q.page_valid, out_q.status == ST_OK, "bad mapping")

endmodule

### rtl/dpfa_ram.sv
// Generic single-port RAM with registered read.
module dpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/tb_demand_paging_frame_allocator_unit.sv
// Testbench for the demand paging frame allocator: directed and random requests, scoreboard check.
`timescale 1ns / 100ps

module tb_demand_paging_frame_allocator_unit;
  import dpfa_pkg::*;

  // Page bookkeeping predictor with a queue of expected result items
  class paging_scoreboard;
    bit          running [PROCESSES];
    int unsigned size_bytes [PROCESSES];
    int unsigned reserved;
    bit          occupied [NFRAMES];
    bit          present [PROCESSES][VPAGES];
    int unsigned frame_of [PROCESSES][VPAGES];
    out_item_t   pending [$];
    int          errors;

    function out_item_t mk(status_e st, int unsigned sl, int unsigned vp, int unsigned fr,
                           bit fresh, bit pv, bit lst);
      out_item_t r;
      r.status = st; r.slot = 3'(sl); r.virtual_page = 4'(vp); r.frame = 8'(fr);
      r.newly_mapped = fresh; r.page_valid = pv; r.last = lst;
      return r;
    endfunction

    function int unsigned page_count(int unsigned bytes);
      return (bytes + PAGE_BYTES - 1) / PAGE_BYTES;
    endfunction

    // Note an accepted request and queue what it should produce
    function void note_request(in_item_t it);
      int unsigned p, a, n, need, first, fin, f;
      bit fresh, found;
      p = it.pid; a = it.addr; n = it.length;
      case (it.op)
        OP_CREATE: begin
          if (n > VIRT_BYTES) begin
            pending.push_back(mk(ST_BOUNDS, 0, 0, 0, 0, 0, 1)); return;
          end
          need = page_count(n);
          if (reserved + need > NFRAMES) begin
            pending.push_back(mk(ST_NO_PAGES, 0, 0, 0, 0, 0, 1)); return;
          end
          for (int s = 0; s < PROCESSES; s++) begin
            if (!running[s]) begin
              running[s] = 1; size_bytes[s] = n; reserved += need;
              for (int v = 0; v < VPAGES; v++) present[s][v] = 0;
              pending.push_back(mk(ST_OK, s, 0, 0, 0, 0, 1));
              return;
            end
          end
          pending.push_back(mk(ST_NO_SLOT, 0, 0, 0, 0, 0, 1));
        end
        OP_NONE: ;
        default: begin
          if (!running[p]) begin
            pending.push_back(mk(ST_NOT_RUNNING, p, 0, 0, 0, 0, 1)); return;
          end
          if (it.op == OP_ACCESS) begin
            if (a + n > size_bytes[p]) begin
              pending.push_back(mk(ST_BOUNDS, p, 0, 0, 0, 0, 1)); return;
            end
            if (n == 0) begin
              pending.push_back(mk(ST_OK, p, 0, 0, 0, 0, 1)); return;
            end
            first = a / PAGE_BYTES; fin = (a + n - 1) / PAGE_BYTES;
            for (int unsigned v = first; v <= fin && v < VPAGES; v++) begin
              fresh = 0;
              if (!present[p][v]) begin
                found = 0;
                for (f = 0; f < NFRAMES; f++) if (!occupied[f]) begin found = 1; break; end
                if (!found) begin
                  pending.push_back(mk(ST_NO_PAGES, p, v, 0, 0, 0, 1)); return;
                end
                occupied[f] = 1; present[p][v] = 1; frame_of[p][v] = f; fresh = 1;
              end
              pending.push_back(mk(ST_OK, p, v, frame_of[p][v], fresh, 1, v == fin));
            end
          end else begin
            // exit: release frames, reservation and slot
            for (int v = 0; v < VPAGES; v++) begin
              if (present[p][v]) occupied[frame_of[p][v]] = 0;
              present[p][v] = 0;
            end
            need = page_count(size_bytes[p]);
            reserved = (reserved >= need) ? reserved - need : 0;
            size_bytes[p] = 0; running[p] = 0;
            pending.push_back(mk(ST_OK, p, 0, 0, 0, 0, 1));
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $realtime, got);
        errors++; return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        $display("%0t result mismatch: expected %p, actual %p", $realtime, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 0;
  out_item_t out_item_o;

  paging_scoreboard board = new();
  int  idle_cycles;

  always #10 clk_i = ~clk_i;

  demand_paging_frame_allocator_unit uut (.*);

  // Scoreboard hooks at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_request(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_item_o);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall before each result, with calm stretches
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Valid stays high from one item to the next when there is no gap
  task automatic send(op_e op, int unsigned pid, int unsigned addr, int unsigned len,
                      int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i <= '{op: op, pid: 3'(pid), addr: 9'(addr), length: 10'(len)};
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait until every expected result has come
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned rgap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  // Random access inside a process, mostly legal
  task automatic random_access();
    int unsigned p, sz, a, n;
    p = $urandom_range(0, 7);
    sz = board.size_bytes[p];
    if ($urandom_range(0, 7) == 0 || sz == 0) begin
      a = $urandom_range(0, 511); n = $urandom_range(0, 512);
    end else begin
      a = $urandom_range(0, sz - 1); n = $urandom_range(0, sz - a);
    end
    send(OP_ACCESS, p, a, n, rgap());
  endtask

  initial begin
    int unsigned r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: limits, errors, full walk, ignored opcode
    send(OP_ACCESS, 0, 0, 1, 0);          // not running
    send(OP_EXIT, 7, 0, 0, 0);            // not running
    send(OP_CREATE, 0, 0, 513, 0);        // too large
    send(OP_CREATE, 5, 0, 512, 0);        // slot 0 full size
    send(OP_ACCESS, 0, 0, 512, 1);        // all 16 pages new
    send(OP_ACCESS, 0, 0, 512, 0);        // all 16 already mapped
    send(OP_ACCESS, 0, 511, 1, 0);
    send(OP_ACCESS, 0, 511, 2, 0);        // past size
    send(OP_ACCESS, 0, 100, 0, 0);        // zero length
    send(OP_CREATE, 0, 0, 0, 0);          // zero-size slot 1
    send(OP_ACCESS, 1, 0, 0, 0);
    send(OP_ACCESS, 1, 0, 1, 0);
    send(OP_NONE, 7, 511, 1023, 0);       // ignored
    send(OP_CREATE, 0, 0, 33, 0);
    send(OP_ACCESS, 2, 31, 2, 0);         // straddles a page boundary
    for (int i = 0; i < 6; i++) send(OP_CREATE, 0, 0, 512, 0);
    send(OP_CREATE, 0, 0, 1, 0);          // no free slot
    send(OP_EXIT, 0, 0, 0, 0);
    send(OP_CREATE, 0, 0, 512, 0);        // reuses slot 0
    // Let everything drain once before the random part
    drain();
    for (int i = 0; i < 8; i++) send(OP_EXIT, i, 0, 0, 0);
    // Random part
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(0, 99);
      if (r < 18) send(OP_CREATE, $urandom_range(0, 7), $urandom_range(0, 511),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 512), rgap());
      else if (r < 80) random_access();
      else if (r < 96) send(OP_EXIT, $urandom_range(0, 7), $urandom_range(0, 511),
                            $urandom_range(0, 1023), rgap());
      else send(OP_NONE, $urandom_range(0, 7), $urandom_range(0, 511),
                $urandom_range(0, 1023), rgap());
      if (i == 150) drain();
    end
    drain();
    repeat (60) @(posedge clk_i);
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
